### src/mcit_pkg.sv
package mcit_pkg;

	localparam int unsigned DEFAULT_CHANNELS = 8;
	localparam int unsigned CMD_W = 2;
	localparam int unsigned CH_FIELD_W = 3;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned MASK_W = 8;
	localparam logic [TIME_W-1:0] RESET_PERIOD = 32'd1000;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK = 2'd0,
		CMD_SETUP = 2'd1,
		CMD_POLL = 2'd2
	} cmd_t;

	typedef struct packed {
		logic tick;
		logic setup;
		logic poll;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] period;
		logic mode;
	} chan_ctrl_t;

	typedef struct packed {
		logic fired;
		logic due;
	} chan_stat_t;

endpackage

### src/mcit_req_if.sv
interface mcit_req_if import mcit_pkg::*; ();
	logic valid;
	logic ready;
	logic [CMD_W-1:0] command;
	logic [CH_FIELD_W-1:0] channel;
	logic [TIME_W-1:0] interval;
	logic fire_on_tick;

	modport source (output valid, output command, output channel, output interval,
		output fire_on_tick, input ready);
	modport sink (input valid, input command, input channel, input interval,
		input fire_on_tick, output ready);
endinterface

### src/mcit_rsp_if.sv
interface mcit_rsp_if import mcit_pkg::*; ();
	logic valid;
	logic ready;
	logic [MASK_W-1:0] fired_mask;
	logic due;

	modport source (output valid, output fired_mask, output due, input ready);
	modport sink (input valid, input fired_mask, input due, output ready);
endinterface

### src/multi_channel_interval_timer_top.sv
// Bank of interval timers on one wrapping 32-bit tick count. Each request (tick, channel
// setup or poll) produces exactly one response: the fired mask for a tick, the due flag for
// a poll, zeros otherwise. A request is registered on entry and its response then sits in the
// output register once it leaves the input register; one request is taken every cycle while responses are
// being drained. Each channel has its own subtract-and-compare path, all evaluated in
// parallel in the cycle after the input register, so the cost per request does not grow
// with the number of channels. Only channels 0 to 7 appear in the fired mask.
module multi_channel_interval_timer_top import mcit_pkg::*; #(
	parameter int unsigned CHANNELS = DEFAULT_CHANNELS
) (
	input logic clk,
	input logic arst_n,
	mcit_req_if.sink req,
	mcit_rsp_if.source rsp
);

	logic valid_s1;
	logic [CMD_W-1:0] command_s1;
	logic [CH_FIELD_W-1:0] channel_s1;
	logic [TIME_W-1:0] interval_s1;
	logic mode_s1;

	logic rsp_valid_q;
	logic [MASK_W-1:0] fired_mask_q;
	logic due_q;
	logic [TIME_W-1:0] count_q;

	logic advance;
	logic fire;
	chan_ctrl_t ctrl;
	chan_stat_t stat [CHANNELS];
	logic [CHANNELS-1:0] sel;
	logic [CHANNELS-1:0] fired;
	logic [CHANNELS-1:0] due_vec;
	logic [MASK_W-1:0] mask;

	assign advance = !rsp_valid_q || rsp.ready;
	assign fire = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	always_comb begin
		ctrl.tick = 1'b0;
		ctrl.setup = 1'b0;
		ctrl.poll = 1'b0;
		unique case (command_s1)
			CMD_TICK: ctrl.tick = 1'b1;
			CMD_SETUP: ctrl.setup = 1'b1;
			CMD_POLL: ctrl.poll = 1'b1;
			default: ;
		endcase
		ctrl.now = count_q + TIME_W'(ctrl.tick);
		ctrl.period = (interval_s1 == '0) ? TIME_W'(1) : interval_s1;
		ctrl.mode = mode_s1;
	end

	for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
		if (i < (1 << CH_FIELD_W)) begin : g_addr
			assign sel[i] = channel_s1 == CH_FIELD_W'(i);
		end else begin : g_noaddr
			assign sel[i] = 1'b0;
		end

		mcit_channel u_chan (
			.clk(clk),
			.arst_n(arst_n),
			.en(fire),
			.sel(sel[i]),
			.ctrl(ctrl),
			.stat(stat[i])
		);

		assign fired[i] = stat[i].fired;
		assign due_vec[i] = stat[i].due;
	end

	for (genvar b = 0; b < MASK_W; b++) begin : g_mask
		if (b < CHANNELS) begin : g_bit
			assign mask[b] = fired[b];
		end else begin : g_zero
			assign mask[b] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
			if (fire && ctrl.tick) begin
				count_q <= ctrl.now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			command_s1 <= req.command;
			channel_s1 <= req.channel;
			interval_s1 <= req.interval;
			mode_s1 <= req.fire_on_tick;
		end
		if (fire) begin
			fired_mask_q <= mask;
			due_q <= |due_vec;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.fired_mask = fired_mask_q;
	assign rsp.due = due_q;

	a_mask_or_due: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.due && rsp.fired_mask != '0))
		else $error("response carries both a fired mask and a due flag");

	a_tick_counts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ctrl.tick |=> count_q == $past(count_q) + TIME_W'(1))
		else $error("tick did not advance the count by one");

	a_count_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && ctrl.tick) |=> $stable(count_q))
		else $error("count moved without a tick transfer");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> valid_s1 && rsp_valid_q && !rsp.ready)
		else $error("request stalled while the pipeline had room");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q)
		else $error("processed request produced no response");

endmodule

### src/mcit_channel.sv
module mcit_channel import mcit_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic sel,
	input chan_ctrl_t ctrl,
	output chan_stat_t stat
);

	logic [TIME_W-1:0] period_q;
	logic [TIME_W-1:0] last_q;
	logic mode_q;
	logic [TIME_W-1:0] elapsed;
	logic expired;
	logic catch_up;
	logic check;

	// The doubled period is compared at one extra bit so it cannot wrap.
	assign elapsed = ctrl.now - last_q;
	assign expired = elapsed >= period_q;
	assign catch_up = {1'b0, elapsed} < {period_q, 1'b0};
	assign check = (ctrl.tick && mode_q) || (ctrl.poll && sel);

	assign stat.fired = ctrl.tick && mode_q && expired;
	assign stat.due = ctrl.poll && sel && expired;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= RESET_PERIOD;
			last_q <= '0;
			mode_q <= 1'b0;
		end else if (en) begin
			if (ctrl.setup && sel) begin
				period_q <= ctrl.period;
				last_q <= ctrl.now;
				mode_q <= ctrl.mode;
			end else if (check && expired) begin
				last_q <= catch_up ? last_q + period_q : ctrl.now;
			end
		end
	end

	a_setup_stamps: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctrl.setup && sel |=> last_q == $past(ctrl.now) && period_q != '0)
		else $error("setup did not stamp the channel");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(last_q) && $stable(period_q) && $stable(mode_q))
		else $error("channel state moved without a transfer");

	a_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		period_q != '0)
		else $error("channel period is zero");

endmodule
